// ===== rtl/vr2d_pkg.sv =====
`timescale 1ns / 1ps

package vr2d_pkg;

  localparam int VR2D_ITERATIONS = 16;
  localparam int VR2D_DATA_WIDTH = 16;
  localparam int ANGLE_WIDTH     = 16;
  localparam int GUARD_BITS      = 16;
  localparam int Z_WIDTH         = 32;
  localparam int HALF_SHIFT      = 24;
  localparam int GAIN_WIDTH      = 32;
  localparam int MAX_ITERATIONS  = 32;

  localparam logic [GAIN_WIDTH-1:0] GAIN_INV = 32'd2608131496;

  // atan(2^-i), 2^32 units per turn, rounded to nearest
  function automatic logic [Z_WIDTH-1:0] atan_val(input int idx);
    logic [Z_WIDTH-1:0] v;
    unique case (idx)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10680094;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      28: v = 32'd3;
      29: v = 32'd1;
      30: v = 32'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/vr2d_quad.sv =====
`timescale 1ns / 1ps

module vr2d_quad #(
  parameter int DATA_WIDTH = vr2d_pkg::VR2D_DATA_WIDTH,
  parameter int W          = DATA_WIDTH + 19
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic signed [DATA_WIDTH-1:0]        point_x_i,
  input  logic signed [DATA_WIDTH-1:0]        point_y_i,
  input  logic [vr2d_pkg::ANGLE_WIDTH-1:0]    angle_i,
  input  logic                                ready_i,
  output logic                                ready_o,
  output logic                                valid_o,
  output logic signed [W-1:0]                 x_o,
  output logic signed [W-1:0]                 y_o,
  output logic signed [vr2d_pkg::Z_WIDTH-1:0] z_o
);

  localparam int AW = vr2d_pkg::ANGLE_WIDTH;
  localparam int ZW = vr2d_pkg::Z_WIDTH;
  localparam int RW = AW - 2;

  logic                 valid_q, valid_d;
  logic signed [W-1:0]  x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0] z_q, z_d;
  logic [AW-1:0]        ang_s;
  logic [1:0]           quad;
  logic signed [RW-1:0] resid;
  logic signed [W-1:0]  px, py, rx, ry;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    ang_s = angle_i + AW'(1 << (RW - 1));
    quad  = ang_s[AW-1:AW-2];
    // residual in [-1/8, +1/8) turn: flip the top residual bit, read as signed
    resid = $signed({~ang_s[RW-1], ang_s[RW-2:0]});
    px    = W'(point_x_i);
    py    = W'(point_y_i);
    unique case (quad)
      2'd1: begin
        rx = -py;
        ry = px;
      end
      2'd2: begin
        rx = -px;
        ry = -py;
      end
      2'd3: begin
        rx = py;
        ry = -px;
      end
      default: begin
        rx = px;
        ry = py;
      end
    endcase
    x_d     = rx <<< vr2d_pkg::GUARD_BITS;
    y_d     = ry <<< vr2d_pkg::GUARD_BITS;
    z_d     = ZW'(resid) <<< 16;
    valid_d = ready_o ? valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule

// ===== rtl/vr2d_cell.sv =====
`timescale 1ns / 1ps

module vr2d_cell #(
  parameter int W     = vr2d_pkg::VR2D_DATA_WIDTH + 19,
  parameter int SHIFT = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic signed [W-1:0]                 x_i,
  input  logic signed [W-1:0]                 y_i,
  input  logic signed [vr2d_pkg::Z_WIDTH-1:0] z_i,
  input  logic                                ready_i,
  output logic                                ready_o,
  output logic                                valid_o,
  output logic signed [W-1:0]                 x_o,
  output logic signed [W-1:0]                 y_o,
  output logic signed [vr2d_pkg::Z_WIDTH-1:0] z_o
);

  localparam int ZW = vr2d_pkg::Z_WIDTH;
  localparam logic signed [ZW-1:0] ATAN = $signed(vr2d_pkg::atan_val(SHIFT));

  logic                 valid_q, valid_d;
  logic signed [W-1:0]  x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0] z_q, z_d;
  logic signed [W-1:0]  dx, dy;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    dx = y_i >>> SHIFT;
    dy = x_i >>> SHIFT;
    if (!z_i[ZW-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ATAN;
    end
    valid_d = ready_o ? valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule

// ===== rtl/vr2d_gain.sv =====
`timescale 1ns / 1ps

module vr2d_gain #(
  parameter int DATA_WIDTH = vr2d_pkg::VR2D_DATA_WIDTH,
  parameter int W          = DATA_WIDTH + 19
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic signed [W-1:0]          x_i,
  input  logic signed [W-1:0]          y_i,
  input  logic                         ready_i,
  output logic                         ready_o,
  output logic                         valid_o,
  output logic signed [DATA_WIDTH:0]   x_o,
  output logic signed [DATA_WIDTH:0]   y_o
);

  localparam int H   = vr2d_pkg::HALF_SHIFT;
  localparam int GW  = vr2d_pkg::GAIN_WIDTH;
  localparam int MW  = W - H;
  localparam int PHW = MW + GW;
  localparam int BW  = H + GW + 1;
  localparam int AW  = PHW + 1;
  localparam int QW  = AW - H;
  localparam int OW  = DATA_WIDTH + 1;

  localparam logic [BW-1:0] ROUND_HALF = BW'(1) << (2 * H - 1);
  localparam logic [QW-1:0] LIM_POS    = (QW'(1) << DATA_WIDTH) - QW'(1);
  localparam logic [QW-1:0] LIM_NEG    = QW'(1) << DATA_WIDTH;

  logic [2:0]         valid_q, valid_d;
  logic [2:0]         rdy;
  logic signed [W-1:0] vin [2];

  logic [1:0]         neg1_q, neg2_q;
  logic [MW-1:0]      mh_q [2];
  logic [H-1:0]       ml_q [2];
  logic [PHW-1:0]     ph_q [2];
  logic [BW-1:0]      b_q  [2];
  logic [OW-1:0]      o_q  [2];

  logic [W-1:0]       mag  [2];
  logic [PHW-1:0]     ph_d [2];
  logic [BW-1:0]      b_d  [2];
  logic [AW-1:0]      acc  [2];
  logic [QW-1:0]      q    [2];
  logic [QW-1:0]      sat  [2];
  logic [OW-1:0]      o_d  [2];

  assign vin[0] = x_i;
  assign vin[1] = y_i;

  assign rdy[2]  = !valid_q[2] || ready_i;
  assign rdy[1]  = !valid_q[1] || rdy[2];
  assign rdy[0]  = !valid_q[0] || rdy[1];
  assign ready_o = rdy[0];

  always_comb begin
    valid_d[0] = rdy[0] ? valid_i    : valid_q[0];
    valid_d[1] = rdy[1] ? valid_q[0] : valid_q[1];
    valid_d[2] = rdy[2] ? valid_q[1] : valid_q[2];
    for (int k = 0; k < 2; k++) begin
      mag[k]  = vin[k][W-1] ? W'(-vin[k]) : W'(vin[k]);
      ph_d[k] = PHW'(mh_q[k]) * PHW'(vr2d_pkg::GAIN_INV);
      b_d[k]  = BW'(ml_q[k]) * BW'(vr2d_pkg::GAIN_INV) + ROUND_HALF;
      acc[k]  = AW'(ph_q[k]) + AW'(b_q[k][BW-1:H]);
      q[k]    = acc[k][AW-1:H];
      if (neg2_q[k]) begin
        sat[k] = (q[k] > LIM_NEG) ? LIM_NEG : q[k];
        o_d[k] = OW'(-sat[k]);
      end else begin
        sat[k] = (q[k] > LIM_POS) ? LIM_POS : q[k];
        o_d[k] = OW'(sat[k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 2; k++) begin
      if (rdy[0] && valid_i) begin
        neg1_q[k] <= vin[k][W-1];
        mh_q[k]   <= mag[k][W-1:H];
        ml_q[k]   <= mag[k][H-1:0];
      end
      if (rdy[1] && valid_q[0]) begin
        neg2_q[k] <= neg1_q[k];
        ph_q[k]   <= ph_d[k];
        b_q[k]    <= b_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2] && valid_q[1]) begin
      o_q[0] <= o_d[0];
      o_q[1] <= o_d[1];
    end
  end

  assign valid_o = valid_q[2];
  assign x_o     = $signed(o_q[0]);
  assign y_o     = $signed(o_q[1]);

endmodule

// ===== rtl/vector_rotate_2d_unit.sv =====
// Rotation by a binary angle: quadrant stage, one CORDIC cell per iteration (at most
// MAX_ITERATIONS), three gain stages. Throughput is one transfer per cycle while the
// output is not stalled; every stage has its own valid and loads when empty or when its
// successor moves, so an output stall holds only the full stages.
// rst_ni asynchronously clears all stage valid bits; payload registers are not reset.
`timescale 1ns / 1ps

module vector_rotate_2d_unit #(
  parameter int ITERATIONS = vr2d_pkg::VR2D_ITERATIONS,
  parameter int DATA_WIDTH = vr2d_pkg::VR2D_DATA_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [DATA_WIDTH-1:0]     point_x_i,
  input  logic signed [DATA_WIDTH-1:0]     point_y_i,
  input  logic [vr2d_pkg::ANGLE_WIDTH-1:0] angle_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [DATA_WIDTH:0]       rotated_x_o,
  output logic signed [DATA_WIDTH:0]       rotated_y_o
);

  localparam int W  = DATA_WIDTH + 19;
  localparam int ZW = vr2d_pkg::Z_WIDTH;
  localparam int NI = (ITERATIONS < vr2d_pkg::MAX_ITERATIONS) ?
                      ITERATIONS : vr2d_pkg::MAX_ITERATIONS;

  logic                 c_valid [NI+1];
  logic                 c_ready [NI+1];
  logic signed [W-1:0]  c_x     [NI+1];
  logic signed [W-1:0]  c_y     [NI+1];
  logic signed [ZW-1:0] c_z     [NI+1];
  logic                 quad_ready;
  logic                 gain_ready;
  logic [DATA_WIDTH:0]  unused_z;

  vr2d_quad #(
    .DATA_WIDTH(DATA_WIDTH),
    .W         (W)
  ) u_quad (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .point_x_i(point_x_i),
    .point_y_i(point_y_i),
    .angle_i  (angle_i),
    .ready_i  (c_ready[0]),
    .ready_o  (quad_ready),
    .valid_o  (c_valid[0]),
    .x_o      (c_x[0]),
    .y_o      (c_y[0]),
    .z_o      (c_z[0])
  );

  for (genvar k = 0; k < NI; k++) begin : g_cell
    vr2d_cell #(
      .W    (W),
      .SHIFT(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(c_valid[k]),
      .x_i    (c_x[k]),
      .y_i    (c_y[k]),
      .z_i    (c_z[k]),
      .ready_i(c_ready[k+1]),
      .ready_o(c_ready[k]),
      .valid_o(c_valid[k+1]),
      .x_o    (c_x[k+1]),
      .y_o    (c_y[k+1]),
      .z_o    (c_z[k+1])
    );
  end

  assign c_ready[NI] = gain_ready;
  assign unused_z    = c_z[NI][DATA_WIDTH:0];

  vr2d_gain #(
    .DATA_WIDTH(DATA_WIDTH),
    .W         (W)
  ) u_gain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(c_valid[NI]),
    .x_i    (c_x[NI]),
    .y_i    (c_y[NI]),
    .ready_i(!out_stall_i),
    .ready_o(gain_ready),
    .valid_o(out_valid_o),
    .x_o    (rotated_x_o),
    .y_o    (rotated_y_o)
  );

  assign in_stall_o = !quad_ready;

  a_idle_out_no_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while the output stage is empty");

  a_empty_quad_no_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !c_valid[0] |-> !in_stall_o)
    else $error("input stalled while the first stage is empty");

  a_transfer_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> c_valid[0])
    else $error("accepted transfer did not reach the first stage");

  a_unused_z_known : assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid[NI] |-> (unused_z == unused_z))
    else $error("residual angle unknown at the last cell");

endmodule
